// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sample generator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define UISG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition in one cycle implies result in the next cycle
`define UISG_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- rtl/uisg_pkg.sv -----
// ---------------------------------------------------------------------------
// uisg_pkg
// Widths, codes and types shared by the sample generator modules.
// ---------------------------------------------------------------------------
package uisg_pkg;

   localparam int INDEX_BITS = 16;
   localparam int MAX_COUNT  = 64;

   localparam int FIELD_W   = 16;
   localparam int IDX_W     = INDEX_BITS;
   localparam int CNT_W     = 7;
   localparam int D2_W      = CNT_W + 1;
   localparam int ALU_W     = IDX_W + 1;
   localparam int DIV_CNT_W = $clog2(ALU_W + 1);
   localparam int STAT_W    = 2;

   localparam logic [STAT_W-1:0] ST_VALID = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_CLASSIFY,
      S_REPORT,
      S_DIVIDE,
      S_EMIT_LOW,
      S_EMIT_STEP,
      S_EMIT_HIGH
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] low_index;
      logic [FIELD_W-1:0] high_index;
      logic [CNT_W-1:0]   point_count;
      logic               with_bounds;
   } req_type;

   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] point;
      logic               last;
      logic [STAT_W-1:0]  status;
   } emit_type;

endpackage

// ----- rtl/uisg_alu.sv -----
// ---------------------------------------------------------------------------
// uisg_alu
// Shared subtract and compare unit: difference and borrow of a minus b.
// ---------------------------------------------------------------------------
module uisg_alu
   import uisg_pkg::*;
(
   input  logic [ALU_W-1:0] op_a,
   input  logic [ALU_W-1:0] op_b,
   output logic [ALU_W-1:0] diff,
   output logic             borrow
);

   logic [ALU_W:0] result;

   assign result = {1'b0, op_a} - {1'b0, op_b};
   assign diff   = result[ALU_W-1:0];
   assign borrow = result[ALU_W];

endmodule

// ----- rtl/uisg_seq.sv -----
// ---------------------------------------------------------------------------
// uisg_seq
// Sequencer: range check, restoring division of the span, point stepping.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uisg_seq
   import uisg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req,
   input  logic     emit_ready,
   output emit_type emit
);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 bnd_ff, bnd_in;
   logic [IDX_W-1:0]     span_ff, span_in;
   logic                 rev_ff, rev_in;
   logic [STAT_W-1:0]    stat_ff, stat_in;
   logic [CNT_W-1:0]     inner_ff, inner_in;
   logic [D2_W-1:0]      div2_ff, div2_in;
   logic [ALU_W-1:0]     dvd_ff, dvd_in;
   logic [ALU_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]     step_index_ff, step_index_in;
   logic [IDX_W-1:0]     pt_ff, pt_in;
   logic [D2_W:0]        racc_ff, racc_in;

   logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic             alu_borrow;

   logic             is_error, is_empty, final_step;
   logic [CNT_W-1:0] inner_calc, step_next;
   logic [ALU_W-1:0] rem_sh;
   logic [D2_W:0]    rsum;
   logic             carry;

   uisg_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   assign is_error   = rev_ff || (ALU_W'(span_ff) < ALU_W'(cnt_ff)) ||
                       (cnt_ff > CNT_W'(MAX_COUNT));
   assign is_empty   = (cnt_ff == '0) || (bnd_ff && (cnt_ff <= CNT_W'(1))) ||
                       (span_ff == '0);
   assign inner_calc = bnd_ff ? CNT_W'(cnt_ff - CNT_W'(2)) : cnt_ff;
   assign step_next  = CNT_W'(step_index_ff + CNT_W'(1));
   assign final_step = (step_next == inner_ff);
   assign rem_sh     = {rem_ff[ALU_W-2:0], dvd_ff[ALU_W-1]};
   assign rsum       = racc_ff + {1'b0, rem_ff[D2_W-1:0]};
   assign carry      = !alu_borrow;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_CLASSIFY;
         end
         S_CLASSIFY: begin
            if (is_error || is_empty) state_in = S_REPORT;
            else                      state_in = S_DIVIDE;
         end
         S_REPORT: begin
            if (emit_ready) state_in = S_IDLE;
         end
         S_DIVIDE: begin
            if (bits_ff == DIV_CNT_W'(1)) begin
               if (bnd_ff) state_in = S_EMIT_LOW;
               else        state_in = S_EMIT_STEP;
            end
         end
         S_EMIT_LOW: begin
            if (emit_ready) begin
               if (inner_ff == '0) state_in = S_EMIT_HIGH;
               else                state_in = S_EMIT_STEP;
            end
         end
         S_EMIT_STEP: begin
            if (emit_ready && final_step) begin
               if (bnd_ff) state_in = S_EMIT_HIGH;
               else        state_in = S_IDLE;
            end
         end
         S_EMIT_HIGH: begin
            if (emit_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      emit.valid  = 1'b0;
      emit.point  = '0;
      emit.last   = 1'b0;
      emit.status = ST_VALID;
      alu_a       = ALU_W'(rsum);
      alu_b       = ALU_W'(div2_ff);
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_CHECK: begin
            alu_a = ALU_W'(hi_ff);
            alu_b = ALU_W'(lo_ff);
         end
         S_REPORT: begin
            emit.valid  = emit_ready;
            emit.last   = 1'b1;
            emit.status = stat_ff;
         end
         S_DIVIDE: begin
            alu_a = rem_sh;
         end
         S_EMIT_LOW: begin
            emit.valid = emit_ready;
            emit.point = FIELD_W'(lo_ff);
         end
         S_EMIT_STEP: begin
            emit.valid = emit_ready;
            emit.point = FIELD_W'(pt_in);
            emit.last  = !bnd_ff && final_step;
         end
         S_EMIT_HIGH: begin
            emit.valid = emit_ready;
            emit.point = FIELD_W'(hi_ff);
            emit.last  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      bnd_in        = bnd_ff;
      span_in       = span_ff;
      rev_in        = rev_ff;
      stat_in       = stat_ff;
      inner_in      = inner_ff;
      div2_in       = div2_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      bits_in       = bits_ff;
      step_index_in = step_index_ff;
      pt_in         = pt_ff;
      racc_in       = racc_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               lo_in  = IDX_W'(req.low_index);
               hi_in  = IDX_W'(req.high_index);
               cnt_in = req.point_count;
               bnd_in = req.with_bounds;
            end
         end
         S_CHECK: begin
            span_in = alu_diff[IDX_W-1:0];
            rev_in  = alu_borrow;
         end
         S_CLASSIFY: begin
            stat_in       = is_error ? ST_ERROR : ST_EMPTY;
            inner_in      = inner_calc;
            div2_in       = {CNT_W'(inner_calc + CNT_W'(1)), 1'b0};
            dvd_in        = {span_ff, 1'b0};
            rem_in        = '0;
            bits_in       = DIV_CNT_W'(ALU_W);
            step_index_in = '0;
            pt_in         = lo_ff;
            racc_in       = (D2_W + 1)'(CNT_W'(inner_calc + CNT_W'(1)));
         end
         S_DIVIDE: begin
            rem_in  = alu_borrow ? rem_sh : alu_diff;
            dvd_in  = {dvd_ff[ALU_W-2:0], !alu_borrow};
            bits_in = DIV_CNT_W'(bits_ff - DIV_CNT_W'(1));
         end
         S_EMIT_STEP: begin
            pt_in = IDX_W'(pt_ff + dvd_ff[IDX_W-1:0] + IDX_W'(carry));
            if (emit_ready) begin
               racc_in       = carry ? alu_diff[D2_W:0] : rsum;
               step_index_in = step_next;
            end else begin
               pt_in = pt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cnt_ff        <= cnt_in;
      bnd_ff        <= bnd_in;
      span_ff       <= span_in;
      rev_ff        <= rev_in;
      stat_ff       <= stat_in;
      inner_ff      <= inner_in;
      div2_ff       <= div2_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      bits_ff       <= bits_in;
      step_index_ff <= step_index_in;
      pt_ff         <= pt_in;
      racc_ff       <= racc_in;
   end

   `UISG_ASSERT(a_racc_below_div, clock, reset, (state_ff == S_EMIT_STEP) |-> (racc_ff < (D2_W + 1)'(div2_ff)))
   `UISG_ASSERT(a_point_in_range, clock, reset, (state_ff == S_EMIT_STEP) |-> (pt_ff <= hi_ff))
   `UISG_ASSERT(a_step_below_inner, clock, reset, (state_ff == S_EMIT_STEP) |-> (step_index_ff < inner_ff))
   `UISG_ASSERT(a_flag_is_last, clock, reset, (emit.valid && emit.status != ST_VALID) |-> (emit.last && emit.point == '0))
   `UISG_ASSERT_NEXT(a_div_done, clock, reset, (state_ff == S_DIVIDE && bits_ff == DIV_CNT_W'(1)), (state_ff == S_EMIT_LOW || state_ff == S_EMIT_STEP))

endmodule

// ----- rtl/uniform_index_sample_generator.sv -----
// After the request transfer the sequencer checks the range, classifies the request and
// divides for INDEX_BITS + 1 quotient bits, then puts the first point in the output register.
// One request at a time: a new request is taken only in idle, after its last response;
// empty and error requests skip the division and emit a single status response.
// Points then leave at one per cycle while the output register is free to take them.
// Reset: synchronous, active high; returns to idle with the output register empty.
// ---------------------------------------------------------------------------
// uniform_index_sample_generator
// Emits evenly spaced sample indices between a low and a high index, or one status word for an empty or error request.
// ---------------------------------------------------------------------------
module uniform_index_sample_generator
   import uisg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,  // low_index[15:0], high_index[31:16], point_count[38:32]
   input  logic              req_tuser,  // with_bounds
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,  // point[15:0]
   output logic              rsp_tlast,
   output logic [STAT_W-1:0] rsp_tuser   // status[1:0]
);

   req_type  req;
   emit_type emit;
   logic     out_free;

   logic                rsp_valid_ff;
   logic [FIELD_W-1:0]  rsp_point_ff;
   logic                rsp_last_ff;
   logic [STAT_W-1:0]   rsp_status_ff;

   assign req.low_index   = req_tdata[15:0];
   assign req.high_index  = req_tdata[31:16];
   assign req.point_count = req_tdata[38:32];
   assign req.with_bounds = req_tuser;

   assign out_free = !rsp_valid_ff || rsp_tready;

   uisg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .emit_ready (out_free),
      .emit       (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_point_ff  <= emit.point;
         rsp_last_ff   <= emit.last;
         rsp_status_ff <= emit.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_point_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
